// ----- hw/rtl/xpld_pkg.sv -----
// Shared types, constants and helper functions for the x86 prologue length decoder.
package xpld_pkg;

    // Window and field geometry.
    localparam int WIN_BYTES   = 12;
    localparam int AVAIL_W     = 13;
    localparam int IDX_W       = 4;
    localparam int LEN_W       = 5;
    localparam int MAX_PREFIXES = 8;
    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 8;

    // Legacy prefix bytes.
    localparam logic [7:0] PFX_OPSIZE  = 8'h66;
    localparam logic [7:0] PFX_ADSIZE  = 8'h67;
    localparam logic [7:0] PFX_REPNE   = 8'hf2;
    localparam logic [7:0] PFX_REP     = 8'hf3;
    localparam logic [7:0] PFX_LOCK    = 8'hf0;
    localparam logic [7:0] PFX_GS      = 8'h65;
    localparam logic [7:0] PFX_FS      = 8'h64;

    // REX byte recognition.
    localparam logic [3:0] REX_HI_NIBBLE = 4'h4;
    localparam int         REX_W_BIT     = 3;

    // Opcodes of the covered subset.
    localparam logic [7:0] OP_PUSH_LO   = 8'h50;
    localparam logic [7:0] OP_POP_HI    = 8'h5f;
    localparam logic [7:0] OP_NOP       = 8'h90;
    localparam logic [7:0] OP_INT3      = 8'hcc;
    localparam logic [7:0] OP_CWDE      = 8'h98;
    localparam logic [7:0] OP_CDQ       = 8'h99;
    localparam logic [7:0] OP_PUSHF     = 8'h9c;
    localparam logic [7:0] OP_POPF      = 8'h9d;
    localparam logic [7:0] OP_MOVI_LO   = 8'hb8;
    localparam logic [7:0] OP_MOVI_HI   = 8'hbf;
    localparam logic [7:0] OP_CALL      = 8'he8;
    localparam logic [7:0] OP_JMP       = 8'he9;
    localparam logic [7:0] OP_JMP8      = 8'heb;
    localparam logic [7:0] OP_PUSH8     = 8'h6a;
    localparam logic [7:0] OP_MOVB_LO   = 8'hb0;
    localparam logic [7:0] OP_MOVB_HI   = 8'hb7;
    localparam logic [7:0] OP_ESC       = 8'h0f;
    localparam logic [7:0] OP_MOV_ST    = 8'h89;
    localparam logic [7:0] OP_MOV_LD    = 8'h8b;
    localparam logic [7:0] OP_LEA       = 8'h8d;
    localparam logic [7:0] OP_ALU_IMM8  = 8'h83;
    localparam logic [7:0] OP_ALU_IMM32 = 8'h81;
    localparam logic [7:0] OP_SUB_LD    = 8'h2b;
    localparam logic [7:0] OP_ADD_LD    = 8'h03;
    localparam logic [7:0] OP_SUB_ST    = 8'h29;
    localparam logic [7:0] OP_ADD_ST    = 8'h01;
    localparam logic [7:0] OP_XOR_ST    = 8'h31;
    localparam logic [7:0] OP_XOR_LD    = 8'h33;

    // ModRM and SIB field codes.
    localparam logic [1:0] MOD_MEM     = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP32  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;
    localparam logic [2:0] RM_SIB      = 3'd4;
    localparam logic [2:0] RM_DISP32   = 3'd5;
    localparam logic [2:0] BASE_DISP32 = 3'd5;

    // Opcode shape classes.
    typedef enum logic [2:0] {
        OPC_NONE,
        OPC_ONE,
        OPC_MOVI,
        OPC_REL32,
        OPC_IMM8,
        OPC_ESC,
        OPC_MODRM
    } t_op_class;

    typedef logic [WIN_BYTES-1:0][7:0] t_window;

    // Request after the prefix scan.
    typedef struct packed {
        t_window              window;
        logic [AVAIL_W-1:0]   avail;
        logic [IDX_W-1:0]     pfx_cnt;
    } t_s1;

    // Request after REX and opcode fetch.
    typedef struct packed {
        logic [7:0]           op;
        logic [7:0]           modrm;
        logic [7:0]           sib;
        logic [IDX_W-1:0]     end_idx;
        logic                 rex_w;
        logic                 fail;
        logic [AVAIL_W-1:0]   avail;
    } t_s2;

    // Result of one request.
    typedef struct packed {
        logic                 decoded;
        logic [LEN_W-1:0]     insn_length;
    } t_res;

    // Byte of the window; indexes past the window read as zero.
    function automatic logic [7:0] code_byte(input t_window win, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < IDX_W'(WIN_BYTES)) begin
            b = win[idx];
        end
        return b;
    endfunction

    function automatic logic is_prefix(input logic [7:0] b);
        return (b == PFX_OPSIZE) || (b == PFX_ADSIZE) || (b == PFX_REPNE) ||
               (b == PFX_REP) || (b == PFX_LOCK) || (b == PFX_GS) || (b == PFX_FS);
    endfunction

endpackage

// ----- hw/rtl/x86_prologue_length_decoder_unit.sv -----
// Top level of the x86-64 instruction length decoder: three-stage pipeline and stream ports.
//
//  channel | direction | fields (tdata, lowest bit first)
//  --------+-----------+------------------------------------------------------------
//  s       | in        | window_low[63:0], window_high[95:64], bytes_available[108:96]
//  m       | out       | insn_length[4:0], decoded[5]
//
// One request is accepted per clock while o_s_tready is high; each result passes through
// the three register stages in order: prefix scan, REX/opcode fetch, length sum.
// Reset clears the stage valid bits only; data registers are not reset.
// When o_m_tvalid is held against a low i_m_tready, the stages fill behind it and input
// ready drops only once every stage holds a request; nothing is dropped or repeated.
module x86_prologue_length_decoder_unit
    import xpld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // window_low, window_high, bytes_available, pad
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata    // insn_length, decoded, pad
);

    logic  w_s1_valid;
    logic  w_s1_ready;
    t_s1   w_s1_data;
    logic  w_s2_valid;
    logic  w_s2_ready;
    t_s2   w_s2_data;
    t_res  w_res;

    // Prefix scan.
    xpld_prefix_stage u_prefix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_window (i_s_tdata[95:0]),
        .i_avail  (i_s_tdata[108:96]),
        .o_valid  (w_s1_valid),
        .i_ready  (w_s1_ready),
        .o_data   (w_s1_data)
    );

    // REX and opcode fetch.
    xpld_opcode_stage u_opcode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1_data),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2_data)
    );

    // Length sum and availability check; its register drives the output.
    xpld_length_stage u_length (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s2_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_res)
    );

    assign o_m_tdata = {{(M_TDATA_W - LEN_W - 1){1'b0}}, w_res.decoded, w_res.insn_length};

    // An accepted request always lands in the first stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> w_s1_valid)
        else $error("accepted request did not enter the prefix stage");

    // The decoded flag agrees with a nonzero length.
    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_res.decoded == (w_res.insn_length != '0)))
        else $error("decoded flag disagrees with length");

    // No covered instruction is longer than twenty bytes.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_res.insn_length <= LEN_W'(20)))
        else $error("instruction length out of range");

    // A full pipeline with a stalled output refuses new requests.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && w_s1_valid && w_s2_valid) |-> !o_s_tready)
        else $error("request taken while every stage is full");

endmodule

// ----- hw/rtl/xpld_prefix_stage.sv -----
// First pipeline stage: counts leading legacy prefixes, bounded by the limit and by availability.
module xpld_prefix_stage
    import xpld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_window              i_window,
    input  logic [AVAIL_W-1:0]   i_avail,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_s1                  o_data
);

    logic             r_valid;
    t_s1              r_data;
    t_s1              n_data;
    logic [IDX_W-1:0] w_run_cnt;
    logic [IDX_W-1:0] w_limit;
    logic             w_run;

    // The stage takes a request when it is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;

    // Count the run of prefixes from byte 0, then clamp to the readable bytes.
    always_comb begin
        w_run_cnt = '0;
        w_run     = 1'b1;
        for (int k = 0; k < MAX_PREFIXES; k++) begin
            if (w_run && is_prefix(code_byte(i_window, IDX_W'(k)))) begin
                w_run_cnt = w_run_cnt + IDX_W'(1);
            end else begin
                w_run = 1'b0;
            end
        end
        if (i_avail < AVAIL_W'(MAX_PREFIXES)) begin
            w_limit = i_avail[IDX_W-1:0];
        end else begin
            w_limit = IDX_W'(MAX_PREFIXES);
        end
        n_data.window  = i_window;
        n_data.avail   = i_avail;
        n_data.pfx_cnt = (w_run_cnt < w_limit) ? w_run_cnt : w_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hw/rtl/xpld_opcode_stage.sv -----
// Second pipeline stage: takes the optional REX byte and fetches opcode, ModRM and SIB bytes.
module xpld_opcode_stage
    import xpld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_s1   i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_s2   o_data
);

    logic             r_valid;
    t_s2              r_data;
    t_s2              n_data;
    logic [7:0]       w_first;
    logic             w_rex;
    logic [IDX_W-1:0] w_op_idx;

    assign o_ready = !r_valid || i_ready;

    // REX is recognized in the byte after the prefixes; the opcode follows it.
    always_comb begin
        w_first  = code_byte(i_data.window, i_data.pfx_cnt);
        w_rex    = (w_first[7:4] == REX_HI_NIBBLE);
        w_op_idx = i_data.pfx_cnt + IDX_W'(w_rex);

        n_data.op      = code_byte(i_data.window, w_op_idx);
        n_data.modrm   = code_byte(i_data.window, w_op_idx + IDX_W'(1));
        n_data.sib     = code_byte(i_data.window, w_op_idx + IDX_W'(2));
        n_data.end_idx = w_op_idx + IDX_W'(1);
        n_data.rex_w   = w_rex && w_first[REX_W_BIT];
        n_data.fail    = (AVAIL_W'(i_data.pfx_cnt) >= i_data.avail) ||
                         (AVAIL_W'(w_op_idx) >= i_data.avail);
        n_data.avail   = i_data.avail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hw/rtl/xpld_length_stage.sv -----
// Third pipeline stage: classifies the opcode, sums the length and checks it against availability.
module xpld_length_stage
    import xpld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_s2   i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_data
);

    logic             r_valid;
    t_res             r_data;
    t_res             n_data;
    t_op_class        w_class;
    logic [1:0]       w_mod;
    logic [2:0]       w_rm;
    logic [LEN_W-1:0] w_base;
    logic [LEN_W-1:0] w_extra;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_chk;
    logic             w_fits;

    assign o_ready = !r_valid || i_ready;

    // Opcode decoder.
    always_comb begin
        unique case (i_data.op) inside
            [OP_PUSH_LO:OP_POP_HI], OP_NOP, OP_INT3, OP_CWDE, OP_CDQ, OP_PUSHF, OP_POPF:
                w_class = OPC_ONE;
            [OP_MOVI_LO:OP_MOVI_HI]:
                w_class = OPC_MOVI;
            OP_CALL, OP_JMP:
                w_class = OPC_REL32;
            OP_JMP8, OP_PUSH8, [OP_MOVB_LO:OP_MOVB_HI]:
                w_class = OPC_IMM8;
            OP_ESC:
                w_class = OPC_ESC;
            OP_MOV_ST, OP_MOV_LD, OP_LEA, OP_ALU_IMM8, OP_ALU_IMM32, OP_SUB_LD,
            OP_ADD_LD, OP_SUB_ST, OP_ADD_ST, OP_XOR_ST, OP_XOR_LD:
                w_class = OPC_MODRM;
            default:
                w_class = OPC_NONE;
        endcase
    end

    // Bytes that follow the opcode, and the length that must be readable.
    always_comb begin
        w_mod   = i_data.modrm[7:6];
        w_rm    = i_data.modrm[2:0];
        w_base  = LEN_W'(i_data.end_idx);
        w_extra = '0;
        unique case (w_class)
            OPC_ONE:   w_extra = '0;
            OPC_MOVI:  w_extra = i_data.rex_w ? LEN_W'(8) : LEN_W'(4);
            OPC_REL32: w_extra = LEN_W'(4);
            OPC_IMM8:  w_extra = LEN_W'(1);
            OPC_ESC:   w_extra = LEN_W'(1);
            OPC_MODRM: begin
                // ModRM byte, then SIB, displacement and immediate.
                w_extra = LEN_W'(1);
                if (w_rm == RM_SIB && w_mod != MOD_REG) begin
                    w_extra = w_extra + LEN_W'(1);
                    if (w_mod == MOD_MEM && i_data.sib[2:0] == BASE_DISP32) begin
                        w_extra = w_extra + LEN_W'(4);
                    end
                end
                if (w_mod == MOD_MEM && w_rm == RM_DISP32) begin
                    w_extra = w_extra + LEN_W'(4);
                end else if (w_mod == MOD_DISP8) begin
                    w_extra = w_extra + LEN_W'(1);
                end else if (w_mod == MOD_DISP32) begin
                    w_extra = w_extra + LEN_W'(4);
                end
                if (i_data.op == OP_ALU_IMM8) begin
                    w_extra = w_extra + LEN_W'(1);
                end
                if (i_data.op == OP_ALU_IMM32) begin
                    w_extra = w_extra + LEN_W'(4);
                end
            end
            OPC_NONE:  w_extra = '0;
            default:   w_extra = '0;
        endcase
        w_len = w_base + w_extra;
        // A 64-bit move immediate only needs four immediate bytes to be readable.
        w_chk = (w_class == OPC_MOVI) ? (w_base + LEN_W'(4)) : w_len;
        w_fits = (AVAIL_W'(w_chk) <= i_data.avail);
        n_data.decoded     = !i_data.fail && (w_class != OPC_NONE) && w_fits;
        n_data.insn_length = n_data.decoded ? w_len : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- test/tb_x86_prologue_length_decoder_unit.sv -----
// Testbench for the x86-64 instruction length decoder, checked against its own length predictor.
module tb_x86_prologue_length_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import xpld_pkg::*;

    // Run limits. The block has a three-stage pipeline.
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;

    // Bytes that the package does not name.
    localparam logic [7:0] OP_RET     = 8'hc3;
    localparam logic [7:0] REX_W_BYTE = {REX_HI_NIBBLE, 4'h8};
    localparam logic [7:0] REX_B_BYTE = {REX_HI_NIBBLE, 4'h1};
    localparam logic [AVAIL_W-1:0] AVAIL_MAX = 13'd4096;

    typedef struct packed {
        logic [LEN_W-1:0] insn_length;
        logic             decoded;
    } t_length_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;   // window_low, window_high, bytes_available, pad
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;        // insn_length, decoded, pad

    t_length_result pending_lengths[$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             burst_left = 1;
    bit             idle_enable = 1'b1;
    logic [31:0]    ready_pattern = 32'hffff_ffff;
    logic [4:0]     ready_phase = '0;

    x86_prologue_length_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Hard stop in case the pipeline hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output stall: walk a 32-bit ready pattern, reloaded with a new shape each lap.
    always @(posedge i_clk) begin
        i_m_tready <= ready_pattern[ready_phase];
        ready_phase <= ready_phase + 5'd1;
        if (ready_phase == 5'd31) begin
            case ($urandom_range(0, 3))
                0: ready_pattern <= 32'hffff_ffff;
                1: ready_pattern <= $urandom;
                2: ready_pattern <= $urandom | $urandom;
                default: ready_pattern <= ($urandom & $urandom) | 32'h8000_0001;
            endcase
        end
    end

    // Byte of a code window; indexes past the window read as zero.
    function automatic logic [7:0] window_byte(input t_window win, input int unsigned idx);
        if (idx < WIN_BYTES) begin
            return win[idx];
        end
        return 8'h00;
    endfunction

    function automatic bit is_legacy_prefix(input logic [7:0] b);
        case (b)
            PFX_OPSIZE, PFX_ADSIZE, PFX_REPNE, PFX_REP, PFX_LOCK, PFX_GS, PFX_FS: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Length of the first instruction, or zero when it is not covered or runs short.
    function automatic logic [LEN_W-1:0] predict_insn_length(input t_window win,
                                                             input logic [AVAIL_W-1:0] avail);
        int unsigned limit;
        int unsigned pos;
        int unsigned len;
        logic        rex_w;
        logic [7:0]  cur;
        logic [7:0]  op;
        logic [7:0]  modrm;
        logic [7:0]  sib;
        limit = avail;
        pos = 0;
        rex_w = 1'b0;
        len = 0;
        while (pos < limit && pos < MAX_PREFIXES && is_legacy_prefix(window_byte(win, pos))) begin
            pos++;
        end
        if (pos >= limit) begin
            return '0;
        end
        cur = window_byte(win, pos);
        if (cur[7:4] == REX_HI_NIBBLE) begin
            rex_w = cur[REX_W_BIT];
            pos++;
        end
        if (pos >= limit) begin
            return '0;
        end
        op = window_byte(win, pos);
        pos++;

        if ((op >= OP_PUSH_LO && op <= OP_POP_HI) || op == OP_NOP || op == OP_INT3 ||
            op == OP_CWDE || op == OP_CDQ || op == OP_PUSHF || op == OP_POPF) begin
            len = pos;
        end else if (op >= OP_MOVI_LO && op <= OP_MOVI_HI) begin
            // Only four immediate bytes are checked, even for the wide form.
            len = (pos + 4 > limit) ? 0 : pos + (rex_w ? 8 : 4);
        end else if (op == OP_CALL || op == OP_JMP) begin
            len = (pos + 4 <= limit) ? pos + 4 : 0;
        end else if (op == OP_JMP8 || op == OP_PUSH8 || (op >= OP_MOVB_LO && op <= OP_MOVB_HI)) begin
            len = (pos + 1 <= limit) ? pos + 1 : 0;
        end else if (op == OP_ESC) begin
            len = (pos >= limit) ? 0 : pos + 1;
        end else if (op == OP_MOV_ST || op == OP_MOV_LD || op == OP_LEA || op == OP_ALU_IMM8 ||
                     op == OP_ALU_IMM32 || op == OP_SUB_LD || op == OP_ADD_LD ||
                     op == OP_SUB_ST || op == OP_ADD_ST || op == OP_XOR_ST || op == OP_XOR_LD) begin
            if (pos >= limit) begin
                return '0;
            end
            modrm = window_byte(win, pos);
            len = pos + 1;
            if (modrm[2:0] == RM_SIB && modrm[7:6] != MOD_REG) begin
                if (len >= limit) begin
                    return '0;
                end
                sib = window_byte(win, len);
                len++;
                if (modrm[7:6] == MOD_MEM && sib[2:0] == BASE_DISP32) begin
                    len += 4;
                end
            end
            if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DISP32) begin
                len += 4;
            end else if (modrm[7:6] == MOD_DISP8) begin
                len += 1;
            end else if (modrm[7:6] == MOD_DISP32) begin
                len += 4;
            end
            if (op == OP_ALU_IMM8) begin
                len += 1;
            end
            if (op == OP_ALU_IMM32) begin
                len += 4;
            end
            if (len > limit) begin
                len = 0;
            end
        end
        return len[LEN_W-1:0];
    endfunction

    // Window from n bytes given right-aligned in reading order; the rest is zero.
    function automatic t_window code_bytes(input logic [95:0] seq, input int n);
        t_window win;
        win = '0;
        for (int k = 0; k < n; k++) begin
            win[k] = seq[8*(n-1-k) +: 8];
        end
        return win;
    endfunction

    function automatic logic [7:0] random_prefix();
        case ($urandom_range(0, 6))
            0: return PFX_OPSIZE;
            1: return PFX_ADSIZE;
            2: return PFX_REPNE;
            3: return PFX_REP;
            4: return PFX_LOCK;
            5: return PFX_GS;
            default: return PFX_FS;
        endcase
    endfunction

    // Any opcode of the covered subset; ModRM forms are drawn most often.
    function automatic logic [7:0] random_opcode();
        case ($urandom_range(0, 9))
            0: return 8'(OP_PUSH_LO + $urandom_range(0, 15));
            1: begin
                case ($urandom_range(0, 5))
                    0: return OP_NOP;
                    1: return OP_INT3;
                    2: return OP_CWDE;
                    3: return OP_CDQ;
                    4: return OP_PUSHF;
                    default: return OP_POPF;
                endcase
            end
            2: return 8'(OP_MOVI_LO + $urandom_range(0, 7));
            3: return $urandom_range(0, 1) ? OP_CALL : OP_JMP;
            4: return $urandom_range(0, 1) ? OP_JMP8 : OP_PUSH8;
            5: return 8'(OP_MOVB_LO + $urandom_range(0, 7));
            6: return OP_ESC;
            default: begin
                case ($urandom_range(0, 10))
                    0: return OP_MOV_ST;
                    1: return OP_MOV_LD;
                    2: return OP_LEA;
                    3: return OP_ALU_IMM8;
                    4: return OP_ALU_IMM32;
                    5: return OP_SUB_LD;
                    6: return OP_ADD_LD;
                    7: return OP_SUB_ST;
                    8: return OP_ADD_ST;
                    9: return OP_XOR_ST;
                    default: return OP_XOR_LD;
                endcase
            end
        endcase
    endfunction

    // Well-formed instruction: prefixes, optional REX and a covered opcode over random bytes.
    function automatic t_window random_instruction();
        t_window win;
        int      pos;
        int      npfx;
        for (int k = 0; k < WIN_BYTES; k++) begin
            win[k] = 8'($urandom);
        end
        pos = 0;
        npfx = $urandom_range(0, 1) ? 0 : $urandom_range(1, MAX_PREFIXES + 1);
        for (int k = 0; k < npfx; k++) begin
            win[pos] = random_prefix();
            pos++;
        end
        if ($urandom_range(0, 2) != 0) begin
            win[pos] = {REX_HI_NIBBLE, 4'($urandom)};
            pos++;
        end
        win[pos] = random_opcode();
        // Favor memory forms with a SIB byte.
        if (pos + 1 < WIN_BYTES && $urandom_range(0, 3) == 0) begin
            win[pos+1][2:0] = RM_SIB;
        end
        return win;
    endfunction

    // Byte count that is mostly right at the edge of the full instruction.
    function automatic logic [AVAIL_W-1:0] random_avail(input t_window win);
        int unsigned full;
        full = predict_insn_length(win, AVAIL_MAX);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return (full != 0) ? AVAIL_W'(full) : AVAIL_W'($urandom_range(0, 13));
            4: return (full != 0) ? AVAIL_W'(full - 1) : '0;
            5: return AVAIL_W'(full + $urandom_range(1, 3));
            6, 7: return AVAIL_W'($urandom_range(0, 13));
            8: return AVAIL_W'($urandom_range(13, 4096));
            default: return AVAIL_MAX;
        endcase
    endfunction

    // Send one request, record its expected length, then pace the input bursts.
    task automatic send_window(input t_window win, input logic [AVAIL_W-1:0] avail);
        logic           taken;
        t_length_result want;
        i_s_tdata <= {3'b000, avail, win};
        i_s_tvalid <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_s_tready;
            @(posedge i_clk);
        end
        want.insn_length = predict_insn_length(win, avail);
        want.decoded = (want.insn_length != '0);
        pending_lengths.push_back(want);
        if (idle_enable) begin
            burst_left--;
            if (burst_left <= 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // Compare every delivered result with the oldest outstanding request.
    always @(negedge i_clk) begin : check_results
        t_length_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_lengths.size() == 0) begin
                $display("%0t: result with no request outstanding: insn_length=%0d decoded=%0b",
                         $time, o_m_tdata[4:0], o_m_tdata[5]);
                mismatch_count++;
            end else begin
                want = pending_lengths.pop_front();
                if (o_m_tdata[4:0] !== want.insn_length) begin
                    $display("%0t: insn_length expected %0d actual %0d",
                             $time, want.insn_length, o_m_tdata[4:0]);
                    mismatch_count++;
                end
                if (o_m_tdata[5] !== want.decoded) begin
                    $display("%0t: decoded expected %0b actual %0b",
                             $time, want.decoded, o_m_tdata[5]);
                    mismatch_count++;
                end
            end
        end
    end

    // Typical function prologue forms over several opcode shapes, and one uncovered opcode.
    task automatic test_prologue_forms();
        send_window(code_bytes({OP_PUSH_LO}, 1), 13'd12);
        send_window(code_bytes({REX_W_BYTE, OP_MOV_ST, MOD_REG, 3'd4, 3'd5}, 3), 13'd12);
        send_window(code_bytes({REX_W_BYTE, OP_ALU_IMM8, MOD_REG, 3'd5, 3'd4, 8'h28}, 4), 13'd4);
        send_window(code_bytes({OP_ALU_IMM32, MOD_DISP32, 3'd0, RM_SIB, 8'h24,
                                32'h1122_3344, 32'h5566_7788}, 11), 13'd11);
        send_window(code_bytes({OP_LEA, MOD_MEM, 3'd1, RM_DISP32, 32'h1000_0000}, 6), 13'd12);
        send_window(code_bytes({OP_MOV_LD, MOD_MEM, 3'd0, RM_SIB, 2'd1, 3'd4, BASE_DISP32,
                                32'hdead_beef}, 7), 13'd12);
        send_window(code_bytes({OP_XOR_ST, MOD_DISP8, 3'd2, 3'd1, 8'hf8}, 3), 13'd12);
        send_window(code_bytes({OP_MOVI_LO, 32'h0000_0001}, 5), 13'd5);
        send_window(code_bytes({OP_ESC, 8'h1f}, 2), 13'd2);
        send_window(code_bytes({OP_RET}, 1), 13'd12);
    endtask

    // Byte counts that end inside the instruction, and the wide move's short check.
    task automatic test_short_bytes();
        send_window('0, '0);
        send_window('1, AVAIL_MAX);
        send_window(code_bytes({OP_CALL, 32'h0}, 5), 13'd4);
        send_window(code_bytes({REX_W_BYTE, OP_MOVI_HI, 64'h0123_4567_89ab_cdef}, 10), 13'd6);
        send_window(code_bytes({REX_W_BYTE, OP_MOVI_HI, 64'h0123_4567_89ab_cdef}, 10), 13'd5);
        send_window(code_bytes({OP_JMP8, 8'h10}, 2), 13'd1);
        send_window(code_bytes({OP_ESC}, 1), 13'd1);
        send_window(code_bytes({REX_B_BYTE}, 1), 13'd1);
        send_window(code_bytes({REX_B_BYTE, OP_PUSH_LO}, 2), 13'd2);
        send_window(code_bytes({OP_ALU_IMM32, MOD_REG, 3'd0, 3'd0, 32'h0000_1000}, 6), 13'd5);
    endtask

    // Prefix runs up to and past the limit, and lengths that reach beyond the window.
    task automatic test_prefix_limit();
        send_window(code_bytes({PFX_OPSIZE, PFX_ADSIZE, PFX_REPNE, PFX_REP, PFX_LOCK, PFX_GS,
                                PFX_FS, PFX_OPSIZE, OP_NOP}, 9), 13'd12);
        send_window(code_bytes({PFX_OPSIZE, PFX_ADSIZE, PFX_REPNE, PFX_REP, PFX_LOCK, PFX_GS,
                                PFX_FS, PFX_OPSIZE, PFX_REP}, 9), 13'd12);
        send_window(code_bytes({PFX_LOCK, PFX_LOCK, PFX_GS, PFX_FS, PFX_REP, PFX_REPNE,
                                PFX_ADSIZE, REX_W_BYTE, OP_MOVI_LO, 24'hffffff}, 12), 13'd13);
        send_window(code_bytes({PFX_LOCK, PFX_LOCK, PFX_GS, PFX_FS, PFX_REP, PFX_REPNE,
                                PFX_ADSIZE, REX_W_BYTE, OP_MOVI_LO, 24'hffffff}, 12), 13'd12);
        send_window(code_bytes({PFX_OPSIZE, OP_ALU_IMM32, MOD_MEM, 3'd0, RM_SIB,
                                2'd0, 3'd0, BASE_DISP32, 32'h0000_0040, 32'h7fff_ffff}, 12),
                    AVAIL_MAX);
    endtask

    // Random well-formed instructions with random byte counts and idling on both sides.
    task automatic test_random_instructions(input int count);
        t_window win;
        for (int n = 0; n < count; n++) begin
            win = random_instruction();
            send_window(win, random_avail(win));
        end
    endtask

    // Arbitrary bytes and byte counts.
    task automatic test_random_noise(input int count);
        t_window win;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < WIN_BYTES; k++) begin
                win[k] = 8'($urandom);
            end
            send_window(win, $urandom_range(0, 1) ? AVAIL_W'($urandom_range(0, 15))
                                                  : AVAIL_W'($urandom_range(0, 4096)));
        end
    endtask

    // Requests on every cycle the block takes them, no input gaps.
    task automatic test_back_to_back(input int count);
        idle_enable = 1'b0;
        test_random_instructions(count);
        idle_enable = 1'b1;
        burst_left = 1;
    endtask

    // Reset, directed cases, random traffic, then drain.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_prologue_forms();
        test_short_bytes();
        test_prefix_limit();
        test_random_instructions(500);
        test_back_to_back(150);
        test_random_noise(200);
        test_random_instructions(350);

        i_s_tvalid <= 1'b0;
        while (pending_lengths.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- x86_prologue_length_decoder_unit.f -----
hw/rtl/xpld_pkg.sv
hw/rtl/xpld_prefix_stage.sv
hw/rtl/xpld_opcode_stage.sv
hw/rtl/xpld_length_stage.sv
hw/rtl/x86_prologue_length_decoder_unit.sv
test/tb_x86_prologue_length_decoder_unit.sv
